>>> src/tbc_pkg.sv
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int WIDTH_REG_BITS = 12;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int RST_FRAME_WIDTH = 128;
    localparam int RST_FRAME_HEIGHT = 48;

    localparam int PIX_BITS = 8;
    localparam int VSUM_BITS = 10;
    localparam int SUM_BITS = 12;
    localparam int NUM_RES = 4;

    typedef logic [PIX_BITS-1:0] pix_t;
    typedef logic [VSUM_BITS-1:0] vsum_t;
    typedef logic [SUM_BITS-1:0] sum_t;

    typedef struct packed {
        pix_t older;
        pix_t prev;
        pix_t cur;
    } column_t;

    typedef struct packed {
        logic y_ge1;
        logic y_ge2;
        logic last_row;
        logic x_ge1;
        logic x_ge2;
        logic x_last;
    } pos_t;

    function automatic int eff_dim(input int value, input int maxv);
        int result;
        if (value == 0)
        begin
            result = 1;
        end
        else if (value > maxv)
        begin
            result = maxv;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

    // Vertical weights 1 2 1 for a result on the row above the current one.
    function automatic vsum_t vert_mid(input column_t t, input logic y_ge2);
        pix_t top;
        top = y_ge2 ? t.older : t.prev;
        return vsum_t'(top) + (vsum_t'(t.prev) << 1) + vsum_t'(t.cur);
    endfunction

    // Vertical weights for a result on the last row, bottom row replicated.
    function automatic vsum_t vert_last(input column_t t, input logic y_ge1);
        pix_t top;
        top = y_ge1 ? t.prev : t.cur;
        return vsum_t'(top) + (vsum_t'(t.cur) << 1) + vsum_t'(t.cur);
    endfunction

    function automatic sum_t horiz_mid(input vsum_t l, input vsum_t m, input vsum_t r);
        return sum_t'(l) + (sum_t'(m) << 1) + sum_t'(r);
    endfunction

    function automatic sum_t horiz_edge(input vsum_t l, input vsum_t c);
        return sum_t'(l) + (sum_t'(c) << 1) + sum_t'(c);
    endfunction

endpackage

>>> src/tbc_ram.sv
`timescale 1ns / 1ps

module tbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tbc_front.sv
`timescale 1ns / 1ps

module tbc_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tbc_pkg::pix_t                       pixel,
    input  logic                                advance,
    output logic                                ram_re,
    output logic [XW-1:0]                       ram_raddr,
    input  logic [2*tbc_pkg::PIX_BITS-1:0]      ram_rdata,
    output logic                                ram_we,
    output logic [XW-1:0]                       ram_waddr,
    output logic [2*tbc_pkg::PIX_BITS-1:0]      ram_wdata,
    output logic                                s1_valid,
    output tbc_pkg::column_t                    s1_col,
    output logic [XW-1:0]                       s1_x,
    output logic [YW-1:0]                       s1_y,
    output tbc_pkg::pos_t                       s1_pos
);

    import tbc_pkg::*;

    localparam logic [XW-1:0] LAST_COL_RST = XW'(eff_dim(RST_FRAME_WIDTH, MAX_WIDTH) - 1);
    localparam logic [YW-1:0] LAST_ROW_RST = YW'(eff_dim(RST_FRAME_HEIGHT, MAX_HEIGHT) - 1);

    logic [XW-1:0] last_col_reg, last_col_next;
    logic [YW-1:0] last_row_reg, last_row_next;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          fwd_reg, fwd_next;
    logic [2*PIX_BITS-1:0] fwd_data_reg;
    pix_t          s1_pix_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    pos_t          s1_pos_reg;
    pos_t          pos_now;
    logic          accept;
    logic [2*PIX_BITS-1:0] taps;

    assign in_ready = !s1_valid_reg || advance;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        pos_now.y_ge1 = (row_reg != '0);
        pos_now.y_ge2 = (row_reg[YW-1:1] != '0);
        pos_now.last_row = (row_reg == last_row_reg);
        pos_now.x_ge1 = (col_reg != '0);
        pos_now.x_ge2 = (col_reg[XW-1:1] != '0);
        pos_now.x_last = (col_reg == last_col_reg);
    end

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    last_col_next = XW'(eff_dim(int'(cfg_data[WIDTH_REG_BITS-1:0]),
                                                MAX_WIDTH) - 1);
                end
                REG_FRAME_HEIGHT:
                begin
                    last_row_next = YW'(eff_dim(int'(cfg_data[HEIGHT_REG_BITS-1:0]),
                                                MAX_HEIGHT) - 1);
                end
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (pos_now.x_last)
            begin
                col_next = '0;
                row_next = pos_now.last_row ? '0 : row_reg + YW'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    assign taps = fwd_reg ? fwd_data_reg : ram_rdata;

    assign ram_re = accept;
    assign ram_raddr = col_reg;
    assign ram_we = advance;
    assign ram_waddr = s1_x_reg;
    assign ram_wdata = {taps[PIX_BITS-1:0], s1_pix_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        fwd_next = fwd_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            fwd_next = advance && (s1_x_reg == col_reg);
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RST;
            last_row_reg <= LAST_ROW_RST;
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg <= col_next;
            row_reg <= row_next;
            s1_valid_reg <= s1_valid_next;
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel;
            s1_x_reg <= col_reg;
            s1_y_reg <= row_reg;
            s1_pos_reg <= pos_now;
            fwd_data_reg <= ram_wdata;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_col.older = taps[2*PIX_BITS-1:PIX_BITS];
    assign s1_col.prev = taps[PIX_BITS-1:0];
    assign s1_col.cur = s1_pix_reg;
    assign s1_x = s1_x_reg;
    assign s1_y = s1_y_reg;
    assign s1_pos = s1_pos_reg;

endmodule

>>> src/tbc_filter.sv
`timescale 1ns / 1ps

module tbc_filter #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           advance,
    input  tbc_pkg::column_t                               col,
    input  logic [XW-1:0]                                  x,
    input  logic [YW-1:0]                                  y,
    input  tbc_pkg::pos_t                                  pos,
    output logic [tbc_pkg::NUM_RES-1:0]                    res_mask,
    output tbc_pkg::sum_t [tbc_pkg::NUM_RES-1:0]           res_val,
    output logic [tbc_pkg::NUM_RES-1:0][XW-1:0]            res_col,
    output logic [tbc_pkg::NUM_RES-1:0][YW-1:0]            res_row
);

    import tbc_pkg::*;

    column_t win0_reg, win0_next;
    column_t win1_reg, win1_next;
    vsum_t   vc_mid, vm1_mid, vm2_mid;
    vsum_t   vc_last, vm1_last, vm2_last;

    always_comb
    begin
        vc_mid = vert_mid(col, pos.y_ge2);
        vm1_mid = vert_mid(win0_reg, pos.y_ge2);
        vm2_mid = pos.x_ge2 ? vert_mid(win1_reg, pos.y_ge2) : vm1_mid;
        vc_last = vert_last(col, pos.y_ge1);
        vm1_last = vert_last(win0_reg, pos.y_ge1);
        vm2_last = pos.x_ge2 ? vert_last(win1_reg, pos.y_ge1) : vm1_last;
    end

    always_comb
    begin
        res_mask[0] = pos.y_ge1 && pos.x_ge1;
        res_val[0] = horiz_mid(vm2_mid, vm1_mid, vc_mid);
        res_col[0] = x - XW'(1);
        res_row[0] = y - YW'(1);

        res_mask[1] = pos.y_ge1 && pos.x_last;
        res_val[1] = horiz_edge(pos.x_ge1 ? vm1_mid : vc_mid, vc_mid);
        res_col[1] = x;
        res_row[1] = y - YW'(1);

        res_mask[2] = pos.last_row && pos.x_ge1;
        res_val[2] = horiz_mid(vm2_last, vm1_last, vc_last);
        res_col[2] = x - XW'(1);
        res_row[2] = y;

        res_mask[3] = pos.last_row && pos.x_last;
        res_val[3] = horiz_edge(pos.x_ge1 ? vm1_last : vc_last, vc_last);
        res_col[3] = x;
        res_row[3] = y;
    end

    always_comb
    begin
        win0_next = win0_reg;
        win1_next = win1_reg;
        if (advance)
        begin
            win1_next = win0_reg;
            win0_next = col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
        end
        else
        begin
            win0_reg <= win0_next;
            win1_reg <= win1_next;
        end
    end

endmodule

>>> src/tbc_outq.sv
`timescale 1ns / 1ps

module tbc_outq #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic [tbc_pkg::NUM_RES-1:0]                    res_mask,
    input  tbc_pkg::sum_t [tbc_pkg::NUM_RES-1:0]           res_val,
    input  logic [tbc_pkg::NUM_RES-1:0][XW-1:0]            res_col,
    input  logic [tbc_pkg::NUM_RES-1:0][YW-1:0]            res_row,
    output logic                                           grp_free,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output tbc_pkg::sum_t                                  blurred,
    output logic [XW-1:0]                                  out_col,
    output logic [YW-1:0]                                  out_row,
    output logic                                           run_last
);

    import tbc_pkg::*;

    logic [NUM_RES-1:0]          mask_reg, mask_next;
    sum_t [NUM_RES-1:0]          val_reg;
    logic [NUM_RES-1:0][XW-1:0]  col_reg;
    logic [NUM_RES-1:0][YW-1:0]  row_reg;
    logic [NUM_RES-1:0]          rest;
    logic [$clog2(NUM_RES)-1:0]  sel;
    logic                        take;

    assign rest = mask_reg & (mask_reg - NUM_RES'(1));
    assign out_valid = (mask_reg != '0);
    assign run_last = (rest == '0);
    assign take = out_valid && out_ready;
    assign grp_free = !out_valid || (take && run_last);

    always_comb
    begin
        sel = '0;
        for (int i = NUM_RES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = ($clog2(NUM_RES))'(i);
            end
        end
    end

    assign blurred = val_reg[sel];
    assign out_col = col_reg[sel];
    assign out_row = row_reg[sel];

    always_comb
    begin
        mask_next = mask_reg;
        priority if (load)
        begin
            mask_next = res_mask;
        end
        else if (take)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= res_val;
            col_reg <= res_col;
            row_reg <= res_row;
        end
    end

endmodule

>>> src/tent_blur_3x3_clamped.sv
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------
// input    | in_valid/in_ready  | pixel
// output   | out_valid/out_ready| blurred, out_col, out_row, run_last
// config   | cfg_write          | cfg_index, cfg_data
//
// One pixel is taken per cycle while ready; the output sends one result per cycle
// unless out_ready is low, so a pixel with n results (up to four, at row ends and
// on the last row) holds the input while they are sent. Its results are registered
// at the output after the line-store read. Reset sets the frame to 128 by 48 and the
// position to the frame start; the line store is not cleared. With out_ready low,
// one pixel waits in the read stage and one group of results at the output.

module tent_blur_3x3_clamped #(
    parameter int MAX_WIDTH = tbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tbc_pkg::pix_t                       pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tbc_pkg::sum_t                       blurred,
    output logic [XW-1:0]                       out_col,
    output logic [YW-1:0]                       out_row,
    output logic                                run_last
);

    import tbc_pkg::*;

    logic                       advance;
    logic                       ram_re;
    logic [XW-1:0]              ram_raddr;
    logic [2*PIX_BITS-1:0]      ram_rdata;
    logic                       ram_we;
    logic [XW-1:0]              ram_waddr;
    logic [2*PIX_BITS-1:0]      ram_wdata;
    logic                       s1_valid;
    column_t                    s1_col;
    logic [XW-1:0]              s1_x;
    logic [YW-1:0]              s1_y;
    pos_t                       s1_pos;
    logic [NUM_RES-1:0]         res_mask;
    sum_t [NUM_RES-1:0]         res_val;
    logic [NUM_RES-1:0][XW-1:0] res_col;
    logic [NUM_RES-1:0][YW-1:0] res_row;
    logic                       grp_free;

    assign advance = s1_valid && ((res_mask == '0) || grp_free);

    tbc_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel(pixel),
        .advance(advance),
        .ram_re(ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .s1_valid(s1_valid),
        .s1_col(s1_col),
        .s1_x(s1_x),
        .s1_y(s1_y),
        .s1_pos(s1_pos)
    );

    tbc_ram #(
        .WIDTH(2 * PIX_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    tbc_filter #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_filter (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .col(s1_col),
        .x(s1_x),
        .y(s1_y),
        .pos(s1_pos),
        .res_mask(res_mask),
        .res_val(res_val),
        .res_col(res_col),
        .res_row(res_row)
    );

    tbc_outq #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_outq (
        .clk(clk),
        .rst_n(rst_n),
        .load(advance && (res_mask != '0)),
        .res_mask(res_mask),
        .res_val(res_val),
        .res_col(res_col),
        .res_row(res_row),
        .grp_free(grp_free),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .blurred(blurred),
        .out_col(out_col),
        .out_row(out_row),
        .run_last(run_last)
    );

endmodule

>>> src/tbc_checker.sv
`timescale 1ns / 1ps

module tbc_checker #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_write,
    input logic [tbc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input logic [tbc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input tbc_pkg::pix_t                       pixel,
    input logic                                out_valid,
    input logic                                out_ready,
    input tbc_pkg::sum_t                       blurred,
    input logic [XW-1:0]                       out_col,
    input logic [YW-1:0]                       out_row,
    input logic                                run_last
);

    import tbc_pkg::*;

    localparam sum_t BLUR_MAX = SUM_BITS'(4080);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blurred) && $stable(out_col)
            && $stable(out_row) && $stable(run_last))
        else $error("Output beat changed while stalled.");

    a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blurred <= BLUR_MAX)
        else $error("Blurred value above the largest weighted sum.");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("Run ended without a beat marked last.");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            (out_row > $past(out_row))
            || ((out_row == $past(out_row)) && (out_col > $past(out_col))))
        else $error("Beats of one run are out of raster order.");

endmodule

bind tent_blur_3x3_clamped tbc_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
) u_tbc_checker (.*);
